### rtl/mfbs_pkg.sv
package mfbs_pkg;

  localparam int WORD_BITS      = 64;
  localparam int WORD_SHIFT     = 6;
  localparam int IDX_W          = 16;
  localparam int LEN_W          = IDX_W + 1;
  localparam int SIZE_W         = 7;
  localparam int WIDX_W         = IDX_W - WORD_SHIFT;
  localparam int MAX_WORDS      = 2 ** WIDX_W;
  localparam int STORE_BITS_DEF = 65536;

  localparam logic [LEN_W-1:0]     LEN_LIMIT = LEN_W'(1) << IDX_W;
  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
  localparam logic [SIZE_W-1:0]    SIZE_MAX  = SIZE_W'(WORD_BITS);

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_FILL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Per-word merge control for one read-modify-write.
  typedef struct packed {
    logic                  is_fill;
    logic                  is_first;
    logic                  is_last;
    logic                  fill_ones;
    logic [WORD_SHIFT-1:0] off;
    logic [WORD_SHIFT-1:0] end_off;
  } merge_ctrl_t;

endpackage

### rtl/mfbs_ram.sv
module mfbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mfbs_merge.sv
module mfbs_merge import mfbs_pkg::*; (
  input  merge_ctrl_t          ctrl,
  input  logic [WIDX_W-1:0]    word_idx,
  input  logic [LEN_W-1:0]     eff_len,
  input  logic [WORD_BITS-1:0] rd_word,
  input  logic [WORD_BITS-1:0] field_top,
  input  logic [WORD_BITS-1:0] mask_top,
  output logic [WORD_BITS-1:0] wr_word
);

  logic [2*WORD_BITS-1:0] field_sh;
  logic [2*WORD_BITS-1:0] mask_sh;
  logic [WORD_BITS-1:0]   fld_word;
  logic [WORD_BITS-1:0]   fld_mask;
  logic [WORD_BITS-1:0]   len_mask;
  logic [WORD_BITS-1:0]   fill_mask;
  logic [WORD_BITS-1:0]   word_mask;
  logic [WORD_BITS-1:0]   word_data;
  logic [WORD_SHIFT-1:0]  ps;
  logic [SIZE_W-1:0]      pe_n;
  logic [WIDX_W:0]        len_word;

  always_comb begin
    // Align the top-justified field to the start offset across two words.
    field_sh = {field_top, WORD_BITS'(0)} >> ctrl.off;
    mask_sh  = {mask_top, WORD_BITS'(0)} >> ctrl.off;
    fld_word = ctrl.is_first ? field_sh[2*WORD_BITS-1:WORD_BITS] : field_sh[WORD_BITS-1:0];
    fld_mask = ctrl.is_first ? mask_sh[2*WORD_BITS-1:WORD_BITS] : mask_sh[WORD_BITS-1:0];

    // Drop bits at or past the length.
    len_word = eff_len[LEN_W-1:WORD_SHIFT];
    if ({1'b0, word_idx} < len_word) begin
      len_mask = WORD_ONES;
    end else if ({1'b0, word_idx} == len_word) begin
      len_mask = ~(WORD_ONES >> eff_len[WORD_SHIFT-1:0]);
    end else begin
      len_mask = '0;
    end

    ps        = ctrl.is_first ? ctrl.off : '0;
    pe_n      = ctrl.is_last ? (SIZE_W'(ctrl.end_off) + SIZE_W'(1)) : SIZE_MAX;
    fill_mask = (WORD_ONES >> ps) & ~(WORD_ONES >> pe_n);

    word_mask = ctrl.is_fill ? fill_mask : (fld_mask & len_mask);
    word_data = ctrl.is_fill ? {WORD_BITS{ctrl.fill_ones}} : fld_word;
    wr_word   = (rd_word & ~word_mask) | (word_data & word_mask);
  end

endmodule

### rtl/msb_first_bit_field_store_top.sv
// Packed bit store, first bit most significant, held in one 64-bit-wide
// single-port-read RAM of STORE_BITS/64 words (at most 1024). Each request
// carries a command: read a field of up to 64 bits, write one, append one at
// the append position, or set/clear an inclusive range. One result comes back
// per request with the field read, an out-of-range flag and the append
// position after the request. After reset the RAM is swept to zero, one word
// per cycle, while requests stall; writing store_length sweeps the words
// wholly past the new length the same way. Requests run one at a time. One
// that touches memory walks the RAM words it covers (1 or 2 for read, write
// and append, the spanned word count for a fill), one word at a time through
// the RAM's single read port, which a read-modify-write walk uses once per
// word. The result sits in an output register, so a new request is taken while
// an earlier result waits.
module msb_first_bit_field_store_top import mfbs_pkg::*; #(
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [IDX_W-1:0]     in_bit_index,
  input  logic [IDX_W-1:0]     in_end_index,
  input  logic [WORD_BITS-1:0] in_field_value,
  input  logic [SIZE_W-1:0]    in_field_size,
  input  logic [WORD_BITS-1:0] in_default_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_read_value,
  output logic                 out_out_of_range,
  output logic [LEN_W-1:0]     out_append_position,
  // length register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEN_W-1:0]     cfg_store_length
);

  localparam int WORD_COUNT = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int MEM_DEPTH  = (WORD_COUNT < MAX_WORDS) ? WORD_COUNT : MAX_WORDS;
  localparam int AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_CAP    = (STORE_BITS < STORE_BITS_DEF) ? STORE_BITS : STORE_BITS_DEF;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
  localparam logic [LEN_W-WORD_SHIFT:0] DEPTH_V = (LEN_W - WORD_SHIFT + 1)'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  // Control state
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [LEN_W-1:0]     eff_len_r, eff_len_nxt;
  logic [LEN_W-1:0]     na_r, na_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 pend_v_r, pend_v_nxt;

  // Request held for the walk
  cmd_t                 cmd_r;
  logic [LEN_W-1:0]     base_r;
  logic [IDX_W-1:0]     end_r;
  logic [WORD_BITS-1:0] val_r;
  logic [SIZE_W-1:0]    sz_r;
  logic [WORD_BITS-1:0] dflt_r;

  // Decoded request
  logic                  bad_r;
  logic [WORD_SHIFT-1:0] off_r;
  logic [WORD_BITS-1:0]  ftop_r;
  logic [WORD_BITS-1:0]  mtop_r;
  logic                  fill_ones_r;
  logic [WIDX_W-1:0]     fw_r;
  logic [WIDX_W-1:0]     lw_r;

  // Walk
  logic [WIDX_W-1:0]    cur_r, cur_nxt;
  logic [WIDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [WORD_BITS-1:0] w0_r, w0_nxt;
  logic [WORD_BITS-1:0] w1_r, w1_nxt;

  // Result register
  logic [WORD_BITS-1:0] out_rd_r, out_rd_nxt;
  logic                 out_bad_r, out_bad_nxt;
  logic [LEN_W-1:0]     out_ap_r, out_ap_nxt;

  // Check-stage terms
  logic [LEN_W:0]        sum_w;
  logic                  sz_big;
  logic                  tail_over;
  logic                  start_out;
  logic                  fill_bad;
  logic [WIDX_W-1:0]     fw_c;
  logic                  span_c;
  logic                  nxt_word_ok;
  logic [LEN_W-1:0]      wr_pos;
  logic [LEN_W-1:0]      fill_pos;
  logic [LEN_W-1:0]      new_pos;
  logic                  bad_c;
  logic                  go_mem;
  logic                  upd_na;

  // Length write terms
  logic [LEN_W-1:0]          cfg_eff;
  logic [LEN_W:0]            cfg_round;
  logic [LEN_W-WORD_SHIFT:0] cfg_ceil;

  // Read composition
  logic [2*WORD_BITS-1:0] win128;
  logic [WORD_BITS-1:0]   rd_field;
  logic [WORD_BITS-1:0]   rd_final;

  // RAM and merge
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] merged;
  merge_ctrl_t          mctrl;

  logic in_acc;
  logic out_acc;
  logic cfg_acc;

  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign out_valid           = out_valid_r;
  assign out_read_value      = out_rd_r;
  assign out_out_of_range    = out_bad_r;
  assign out_append_position = out_ap_r;

  // Range checks and word span of the held request.
  always_comb begin
    sum_w       = {1'b0, base_r} + (LEN_W + 1)'(sz_r);
    sz_big      = sz_r > SIZE_MAX;
    tail_over   = sum_w > {1'b0, eff_len_r};
    start_out   = base_r >= eff_len_r;
    fill_bad    = (base_r[IDX_W-1:0] > end_r) || (LEN_W'(end_r) >= eff_len_r);
    fw_c        = base_r[IDX_W-1:WORD_SHIFT];
    span_c      = (8'(base_r[WORD_SHIFT-1:0]) + 8'(sz_r)) > 8'(WORD_BITS);
    nxt_word_ok = {(WIDX_W + 1)'(fw_c) + (WIDX_W + 1)'(1), WORD_SHIFT'(0)} < eff_len_r;
    wr_pos      = tail_over ? eff_len_r : sum_w[LEN_W-1:0];
    fill_pos    = LEN_W'(end_r) + LEN_W'(1);

    case (cmd_r)
      CMD_READ: begin
        bad_c   = sz_big || tail_over;
        go_mem  = !bad_c && (sz_r != '0);
        upd_na  = 1'b0;
        new_pos = wr_pos;
      end
      CMD_WRITE, CMD_APPEND: begin
        bad_c   = sz_big || start_out || tail_over;
        go_mem  = !(sz_big || start_out) && (sz_r != '0);
        upd_na  = go_mem;
        new_pos = wr_pos;
      end
      CMD_FILL: begin
        bad_c   = fill_bad;
        go_mem  = !fill_bad;
        upd_na  = !fill_bad;
        new_pos = fill_pos;
      end
      default: begin
        bad_c   = 1'b1;
        go_mem  = 1'b0;
        upd_na  = 1'b0;
        new_pos = wr_pos;
      end
    endcase
  end

  // Length write: clamp and find the first word wholly past it.
  always_comb begin
    cfg_eff   = (cfg_store_length > LEN_CAP_V) ? LEN_CAP_V : cfg_store_length;
    cfg_round = (LEN_W + 1)'(cfg_eff) + (LEN_W + 1)'(WORD_BITS - 1);
    cfg_ceil  = cfg_round[LEN_W:WORD_SHIFT];
  end

  // Read field: shift the two words up to the start, keep the top sz bits.
  always_comb begin
    win128   = {w0_r, w1_r} << off_r;
    rd_field = win128[2*WORD_BITS-1:WORD_BITS] >> (SIZE_MAX - sz_r);
    if (cmd_r == CMD_READ) begin
      rd_final = bad_r ? dflt_r : rd_field;
    end else begin
      rd_final = '0;
    end
  end

  always_comb begin
    mctrl.is_fill   = (cmd_r == CMD_FILL);
    mctrl.is_first  = (pend_idx_r == fw_r);
    mctrl.is_last   = (pend_idx_r == lw_r);
    mctrl.fill_ones = fill_ones_r;
    mctrl.off       = off_r;
    mctrl.end_off   = end_r[WORD_SHIFT-1:0];
  end

  mfbs_merge u_merge (
    .ctrl      (mctrl),
    .word_idx  (pend_idx_r),
    .eff_len   (eff_len_r),
    .rd_word   (ram_rdata),
    .field_top (ftop_r),
    .mask_top  (mtop_r),
    .wr_word   (merged)
  );

  // RAM ports: the sweep writes zeros; the walk reads the current word and
  // writes back the word read in the cycle before, never the same address.
  always_comb begin
    ram_re = (state_r == ST_WALK);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_v_r && (cmd_r != CMD_READ);
      ram_waddr = pend_idx_r[AW-1:0];
      ram_wdata = merged;
    end
  end

  mfbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    eff_len_nxt   = eff_len_r;
    na_nxt        = na_r;
    out_valid_nxt = out_valid_r;
    pend_v_nxt    = pend_v_r;
    cur_nxt       = cur_r;
    pend_idx_nxt  = pend_idx_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    out_rd_nxt    = out_rd_r;
    out_bad_nxt   = out_bad_r;
    out_ap_nxt    = out_ap_r;

    // Free the result register once taken.
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    // Capture read words as they return.
    if (pend_v_r && (cmd_r == CMD_READ)) begin
      if (pend_idx_r == fw_r) begin
        w0_nxt = ram_rdata;
      end else begin
        w1_nxt = ram_rdata;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cur_nxt    = fw_c;
        pend_v_nxt = 1'b0;
        if (upd_na && (new_pos > na_r)) begin
          na_nxt = new_pos;
        end
        state_nxt = go_mem ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = cur_r;
        if (cur_r == lw_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cur_nxt = cur_r + WIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        pend_v_nxt = 1'b0;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the result register has room.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_final;
          out_bad_nxt   = bad_r;
          out_ap_nxt    = na_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Length write: sweep every word wholly past the new length. A sweep
    // already running from below that point covers it.
    if (cfg_acc) begin
      eff_len_nxt = cfg_eff;
      if (!((state_r == ST_CLEAR) && ((LEN_W - WORD_SHIFT + 1)'(clr_r) < cfg_ceil))) begin
        if (cfg_ceil < DEPTH_V) begin
          clr_nxt   = cfg_ceil[AW-1:0];
          state_nxt = ST_CLEAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      eff_len_r   <= '0;
      na_r        <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      eff_len_r   <= eff_len_nxt;
      na_r        <= na_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_t'(in_command);
      base_r <= (cmd_t'(in_command) == CMD_APPEND) ? na_r : LEN_W'(in_bit_index);
      end_r  <= in_end_index;
      val_r  <= in_field_value;
      sz_r   <= in_field_size;
      dflt_r <= in_default_value;
    end
    if (state_r == ST_CHECK) begin
      bad_r       <= bad_c;
      off_r       <= base_r[WORD_SHIFT-1:0];
      ftop_r      <= val_r << (SIZE_MAX - sz_r);
      mtop_r      <= ~(WORD_ONES >> sz_r);
      fill_ones_r <= |val_r;
      fw_r        <= fw_c;
      lw_r        <= (cmd_r == CMD_FILL) ? end_r[IDX_W-1:WORD_SHIFT] :
                     fw_c + WIDX_W'(span_c && nxt_word_ok);
    end
    cur_r      <= cur_nxt;
    pend_idx_r <= pend_idx_nxt;
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    out_rd_r   <= out_rd_nxt;
    out_bad_r  <= out_bad_nxt;
    out_ap_r   <= out_ap_nxt;
  end

endmodule

### rtl/mfbs_checker.sv
module mfbs_checker import mfbs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_BITS-1:0] out_read_value,
  input logic                 out_out_of_range,
  input logic [LEN_W-1:0]     out_append_position
);

  logic [LEN_W-1:0] last_ap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ap_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_ap_r <= out_append_position;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) &&
      $stable(out_out_of_range) && $stable(out_append_position))
    else $error("result changed while stalled");

  // One request in flight: the cycle after acceptance stalls.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // The clearing sweep after reset blocks requests.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request path open right after reset");

  // The append position never moves backward between results.
  a_ap_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> out_append_position >= last_ap_r)
    else $error("append position went backward");

  a_ap_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_append_position <= LEN_LIMIT)
    else $error("append position beyond the store");

endmodule

bind msb_first_bit_field_store_top mfbs_checker u_mfbs_checker (.*);
